@@ src/lbn_pkg.sv @@
`timescale 1ns / 1ps

package lbn_pkg;

	// Default counter width for line, column and offset tracking.
	localparam int LBN_COUNT_WIDTH = 32;

	// Width of the start registers and of the configuration data bus.
	localparam int LBN_REG_WIDTH = 32;

	// Configuration register indexes.
	localparam logic LBN_CFG_START_LINE   = 1'b0;
	localparam logic LBN_CFG_START_COLUMN = 1'b1;

	// Characters of interest.
	localparam logic [7:0] LBN_CH_LF = 8'h0A;
	localparam logic [7:0] LBN_CH_CR = 8'h0D;

	// UTF-8 continuation bytes look like 10xxxxxx.
	localparam logic [1:0] LBN_UTF8_CONT_TAG = 2'b10;

	// Pending-break tracker state.
	typedef enum logic [1:0] {
		BRK_NONE = 2'd0,
		BRK_LF   = 2'd1,
		BRK_CR   = 2'd2
	} brk_t;

endpackage

@@ src/lbn_tracker.sv @@
`timescale 1ns / 1ps

module lbn_tracker import lbn_pkg::*; #(
	parameter int COUNT_WIDTH = LBN_COUNT_WIDTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     restart,
	input  logic [LBN_REG_WIDTH-1:0] start_line,
	input  logic [LBN_REG_WIDTH-1:0] start_column,
	input  logic                     step,
	input  logic [7:0]               byte_in,
	output logic                     emit,
	output logic [7:0]               char_nxt,
	output logic [COUNT_WIDTH-1:0]   line_nxt,
	output logic [COUNT_WIDTH-1:0]   column_nxt,
	output logic [COUNT_WIDTH-1:0]   offset_nxt
);

	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
	localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

	function automatic logic [COUNT_WIDTH-1:0] clamp_cnt(input logic [LBN_REG_WIDTH-1:0] v);
		logic [63:0] ext;
		ext = 64'(v);
		if (ext > 64'(CNT_MAX)) begin
			return CNT_MAX;
		end
		return COUNT_WIDTH'(ext);
	endfunction

	function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
		return (v == CNT_MAX) ? v : v + CNT_ONE;
	endfunction

	brk_t                   brk_q;
	brk_t                   brk_nxt;
	logic [COUNT_WIDTH-1:0] line_q;
	logic [COUNT_WIDTH-1:0] column_q;
	logic [COUNT_WIDTH-1:0] bytes_q;
	logic [COUNT_WIDTH-1:0] offset_q;
	logic [COUNT_WIDTH-1:0] bytes_nxt;
	logic                   is_nl;
	logic                   pair_end;
	logic                   is_break;
	logic                   is_cont;

	always_comb begin
		is_nl    = (byte_in == LBN_CH_LF) || (byte_in == LBN_CH_CR);
		// Second byte of a CRLF or LFCR pair: swallow it.
		pair_end = ((brk_q == BRK_LF) && (byte_in == LBN_CH_CR)) ||
		           ((brk_q == BRK_CR) && (byte_in == LBN_CH_LF));
		is_break = is_nl && !pair_end;
		emit     = !pair_end;
		is_cont  = (byte_in[7:6] == LBN_UTF8_CONT_TAG);

		if (is_break) begin
			brk_nxt = (byte_in == LBN_CH_LF) ? BRK_LF : BRK_CR;
		end else begin
			brk_nxt = BRK_NONE;
		end

		bytes_nxt = sat_inc(bytes_q);
		char_nxt  = is_break ? LBN_CH_LF : byte_in;

		line_nxt   = line_q;
		column_nxt = column_q;
		offset_nxt = offset_q;
		if (is_break) begin
			line_nxt   = sat_inc(line_q);
			column_nxt = CNT_ONE;
			offset_nxt = bytes_nxt;
		end else if (emit && !is_cont) begin
			column_nxt = sat_inc(column_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brk_q    <= BRK_NONE;
			line_q   <= CNT_ONE;
			column_q <= CNT_ONE;
			bytes_q  <= '0;
			offset_q <= '0;
		end else if (restart) begin
			brk_q    <= BRK_NONE;
			line_q   <= clamp_cnt(start_line);
			column_q <= clamp_cnt(start_column);
			bytes_q  <= '0;
			offset_q <= '0;
		end else if (step) begin
			brk_q    <= brk_nxt;
			line_q   <= line_nxt;
			column_q <= column_nxt;
			bytes_q  <= bytes_nxt;
			offset_q <= offset_nxt;
		end
	end

endmodule

@@ src/linebreak_normalizer_line_column_top.sv @@
`timescale 1ns / 1ps

// Line-break normalizer with line/column tracking. Takes one raw text byte
// per transfer on the input channel and turns LF, CR, CRLF and LFCR into a
// single LF; the second byte of a pair produces no output transfer, while
// repeated LFs or repeated CRs each count as a new break. Every output
// carries the normalized byte, the line and column after it, and the raw
// byte offset just past the most recent break. UTF-8 continuation bytes
// do not advance the column; all counters saturate. The block sustains one
// byte per cycle: the tracker's next state is combinational on the
// input register, and a result register decouples the output side, so a
// byte enters on every cycle that the output is not stalled. The output
// is registered behind the input register. Writing start_line (index 0)
// or start_column (index 1) stores the value and restarts the tracker,
// loading the counters from the start registers; write only while idle.
module linebreak_normalizer_line_column_top import lbn_pkg::*; #(
	parameter int COUNT_WIDTH = LBN_COUNT_WIDTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// configuration
	input  logic                     cfg_we,
	input  logic                     cfg_index,
	input  logic [LBN_REG_WIDTH-1:0] cfg_data,
	// input channel
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [7:0]               byte_in,
	// output channel
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [7:0]               char_out,
	output logic [31:0]              line_number,
	output logic [31:0]              column_number,
	output logic [31:0]              break_offset
);

	// Start registers.
	logic [LBN_REG_WIDTH-1:0] start_line_q;
	logic [LBN_REG_WIDTH-1:0] start_column_q;
	logic [LBN_REG_WIDTH-1:0] start_line_new;
	logic [LBN_REG_WIDTH-1:0] start_column_new;

	// Input register stage.
	logic       valid_s1;
	logic [7:0] byte_s1;

	// Result register.
	logic        out_valid_q;
	logic [7:0]  char_q;
	logic [31:0] line_q;
	logic [31:0] column_q;
	logic [31:0] offset_q;

	// Tracker results for the byte in stage 1.
	logic                   emit;
	logic [7:0]             char_nxt;
	logic [COUNT_WIDTH-1:0] line_nxt;
	logic [COUNT_WIDTH-1:0] column_nxt;
	logic [COUNT_WIDTH-1:0] offset_nxt;

	logic out_free;
	logic advance_s1;
	logic in_xfer;

	// The restart must see the value being written this cycle, so forward it.
	always_comb begin
		start_line_new   = start_line_q;
		start_column_new = start_column_q;
		unique case (cfg_index)
			LBN_CFG_START_LINE:   start_line_new   = cfg_data;
			LBN_CFG_START_COLUMN: start_column_new = cfg_data;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_line_q   <= LBN_REG_WIDTH'(1);
			start_column_q <= LBN_REG_WIDTH'(1);
		end else if (cfg_we) begin
			start_line_q   <= start_line_new;
			start_column_q <= start_column_new;
		end
	end

	// Handshake: stage 1 moves on when its byte is swallowed or the result
	// register has room; a new byte enters whenever stage 1 is empty or moving.
	assign out_free   = !out_valid_q || out_ready;
	assign advance_s1 = valid_s1 && (!emit || out_free);
	assign in_ready   = !valid_s1 || advance_s1;
	assign in_xfer    = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Hold the payload until the next transfer.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			byte_s1 <= byte_in;
		end
	end

	lbn_tracker #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_tracker (
		.clk          (clk),
		.arst_n       (arst_n),
		.restart      (cfg_we),
		.start_line   (start_line_new),
		.start_column (start_column_new),
		.step         (advance_s1),
		.byte_in      (byte_s1),
		.emit         (emit),
		.char_nxt     (char_nxt),
		.line_nxt     (line_nxt),
		.column_nxt   (column_nxt),
		.offset_nxt   (offset_nxt)
	);

	// Result register: load on an emitting advance, drop valid once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && emit) begin
			char_q   <= char_nxt;
			line_q   <= 32'(line_nxt);
			column_q <= 32'(column_nxt);
			offset_q <= 32'(offset_nxt);
		end
	end

	assign out_valid     = out_valid_q;
	assign char_out      = char_q;
	assign line_number   = line_q;
	assign column_number = column_q;
	assign break_offset  = offset_q;

endmodule
